[rtl/core/brhp_pkg.sv]
// Shared types and constants for the byte range header parser.
package brhp_pkg;

    typedef enum logic [3:0] {
        PH_WS       = 4'd0,
        PH_UNIT     = 4'd1,
        PH_AFTER_EQ = 4'd2,
        PH_SUFFIX   = 4'd3,
        PH_SUFDONE  = 4'd4,
        PH_START    = 4'd5,
        PH_DASH     = 4'd6,
        PH_OPEN     = 4'd7,
        PH_END      = 4'd8,
        PH_CLOSED   = 4'd9,
        PH_BAD      = 4'd10
    } t_phase;

    localparam logic [63:0] MAX_POS   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_FFFF;

    // Parser state at the end of one header value
    typedef struct packed {
        t_phase      phase;
        logic [63:0] first_num;
        logic [63:0] second_num;
        logic        ovf;
    } t_snap;

endpackage

[rtl/core/brhp_parse.sv]
// Character-level parser state and end-of-value snapshot register.
module brhp_parse (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_ch,
    input  logic                i_has_char,
    input  logic                i_last,
    output brhp_pkg::t_snap     o_snap
);

    localparam logic [7:0]  CH_EQ    = 8'h3D;
    localparam logic [7:0]  CH_DASH  = 8'h2D;
    localparam logic [7:0]  CH_COMMA = 8'h2C;
    localparam logic [7:0]  CH_ZERO  = 8'h30;
    localparam logic [7:0]  CH_NINE  = 8'h39;
    localparam logic [7:0]  CH_SPACE = 8'h20;
    localparam logic [2:0]  UNIT_LEN = 3'd5;
    // (MAX_POS - d) / 10: one value for digits 0..7, one below for 8 and 9
    localparam logic [63:0] LIM_LO   = 64'd922337203685477580;
    localparam logic [63:0] LIM_HI   = 64'd922337203685477579;

    function automatic logic [7:0] unit_char(input logic [2:0] pos);
        case (pos)
            3'd0:    unit_char = 8'h62; // b
            3'd1:    unit_char = 8'h79; // y
            3'd2:    unit_char = 8'h74; // t
            3'd3:    unit_char = 8'h65; // e
            3'd4:    unit_char = 8'h73; // s
            default: unit_char = 8'h00;
        endcase
    endfunction

    brhp_pkg::t_phase r_phase, n_phase;
    logic [2:0]       r_pos, n_pos;
    logic             r_mis, n_mis;
    logic [63:0]      r_first, n_first;
    logic [63:0]      r_second, n_second;
    logic             r_ovf, n_ovf;
    brhp_pkg::t_snap  r_snap;

    logic        is_ws, is_digit, do_unit;
    logic [3:0]  digit;
    logic        acc_second, acc_clear;
    logic [63:0] acc_base, acc_val;
    logic        acc_ovf;

    assign is_ws    = (i_ch == CH_SPACE) || (i_ch >= 8'd9 && i_ch <= 8'd13);
    assign is_digit = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
    assign digit    = 4'(i_ch - CH_ZERO);

    // shared multiply-by-ten accumulator
    always_comb begin
        acc_base = acc_clear ? 64'd0 : (acc_second ? r_second : r_first);
        acc_ovf  = acc_base > ((digit <= 4'd7) ? LIM_LO : LIM_HI);
        acc_val  = (acc_base << 3) + (acc_base << 1) + {60'd0, digit};
        if (acc_ovf) begin
            acc_val = acc_base;
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_mis      = r_mis;
        n_first    = r_first;
        n_second   = r_second;
        n_ovf      = r_ovf;
        do_unit    = 1'b0;
        acc_second = (r_phase == brhp_pkg::PH_DASH) || (r_phase == brhp_pkg::PH_END);
        acc_clear  = (r_phase == brhp_pkg::PH_AFTER_EQ) || (r_phase == brhp_pkg::PH_DASH);
        if (i_has_char) begin
            unique case (r_phase)
                brhp_pkg::PH_WS: begin
                    do_unit = !is_ws;
                end
                brhp_pkg::PH_UNIT: begin
                    do_unit = 1'b1;
                end
                brhp_pkg::PH_AFTER_EQ: begin
                    if (i_ch == CH_DASH) begin
                        n_first = 64'd0;
                        n_phase = brhp_pkg::PH_SUFFIX;
                    end else if (is_digit) begin
                        n_first = acc_val;
                        n_phase = brhp_pkg::PH_START;
                    end else begin
                        n_phase = brhp_pkg::PH_BAD;
                    end
                end
                brhp_pkg::PH_SUFFIX: begin
                    if (is_digit) begin
                        n_first = acc_val;
                        n_ovf   = r_ovf | acc_ovf;
                    end else begin
                        n_phase = brhp_pkg::PH_SUFDONE;
                    end
                end
                brhp_pkg::PH_START: begin
                    if (is_digit) begin
                        n_first = acc_val;
                        n_ovf   = r_ovf | acc_ovf;
                    end else begin
                        n_phase = (i_ch == CH_DASH) ? brhp_pkg::PH_DASH : brhp_pkg::PH_BAD;
                    end
                end
                brhp_pkg::PH_DASH: begin
                    if (i_ch == CH_COMMA || is_ws) begin
                        n_phase = brhp_pkg::PH_OPEN;
                    end else if (is_digit) begin
                        n_second = acc_val;
                        n_phase  = brhp_pkg::PH_END;
                    end else begin
                        n_phase = brhp_pkg::PH_BAD;
                    end
                end
                brhp_pkg::PH_END: begin
                    if (is_digit) begin
                        n_second = acc_val;
                        n_ovf    = r_ovf | acc_ovf;
                    end else begin
                        n_phase = (i_ch == CH_COMMA || is_ws) ? brhp_pkg::PH_CLOSED
                                                              : brhp_pkg::PH_BAD;
                    end
                end
                default: begin
                    // finished or broken forms ignore the rest
                end
            endcase
            if (do_unit) begin
                n_phase = brhp_pkg::PH_UNIT;
                if (i_ch == CH_EQ) begin
                    n_phase = (r_pos == UNIT_LEN && !r_mis) ? brhp_pkg::PH_AFTER_EQ
                                                            : brhp_pkg::PH_BAD;
                end else if (r_pos < UNIT_LEN && i_ch == unit_char(r_pos)) begin
                    n_pos = r_pos + 3'd1;
                end else begin
                    n_mis = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= brhp_pkg::PH_WS;
            r_pos    <= 3'd0;
            r_mis    <= 1'b0;
            r_first  <= 64'd0;
            r_second <= 64'd0;
            r_ovf    <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                // start afresh for the next header value
                r_phase  <= brhp_pkg::PH_WS;
                r_pos    <= 3'd0;
                r_mis    <= 1'b0;
                r_first  <= 64'd0;
                r_second <= 64'd0;
                r_ovf    <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_pos    <= n_pos;
                r_mis    <= n_mis;
                r_first  <= n_first;
                r_second <= n_second;
                r_ovf    <= n_ovf;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && i_last) begin
            r_snap.phase      <= n_phase;
            r_snap.first_num  <= n_first;
            r_snap.second_num <= n_second;
            r_snap.ovf        <= n_ovf;
        end
    end

    assign o_snap = r_snap;

endmodule

[rtl/core/brhp_result.sv]
// Range evaluation from the end-of-value snapshot, with the result register.
module brhp_result (
    input  logic               i_clk,
    input  logic               i_load,
    input  brhp_pkg::t_snap    i_snap,
    output logic               o_status,
    output logic signed [63:0] o_range_start,
    output logic signed [63:0] o_range_length
);

    logic        ok;
    logic [63:0] start_v, len_v, diff;
    logic [64:0] diff_w;
    logic        r_status;
    logic [63:0] r_start, r_len;

    assign diff_w = {1'b0, i_snap.second_num} - {1'b0, i_snap.first_num};
    assign diff   = diff_w[63:0];

    always_comb begin
        ok      = 1'b0;
        start_v = 64'd0;
        len_v   = 64'd0;
        case (i_snap.phase)
            brhp_pkg::PH_SUFFIX, brhp_pkg::PH_SUFDONE: begin
                ok      = (i_snap.first_num != 64'd0) && !i_snap.ovf;
                start_v = brhp_pkg::MINUS_ONE;
                len_v   = i_snap.first_num;
            end
            brhp_pkg::PH_DASH, brhp_pkg::PH_OPEN: begin
                ok      = !i_snap.ovf;
                start_v = i_snap.first_num;
                len_v   = brhp_pkg::MINUS_ONE;
            end
            brhp_pkg::PH_END, brhp_pkg::PH_CLOSED: begin
                // borrow clear means end >= start
                ok      = !i_snap.ovf && !diff_w[64] && (diff < brhp_pkg::MAX_POS);
                start_v = i_snap.first_num;
                len_v   = diff + 64'd1;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
        if (!ok) begin
            start_v = 64'd0;
            len_v   = 64'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_status <= !ok;
            r_start  <= start_v;
            r_len    <= len_v;
        end
    end

    assign o_status       = r_status;
    assign o_range_start  = signed'(r_start);
    assign o_range_length = signed'(r_len);

endmodule

[rtl/core/byte_range_header_parser_top.sv]
// Top level of the byte range header parser: handshakes and pipeline registers.
//
// Input channel: one header character per request (i_ch, i_has_char, i_last),
// taken on a rising edge with i_valid high and o_stall low. i_has_char low
// marks a pure end marker; i_last closes the header value.
// Output channel: one result (o_status, o_range_start, o_range_length) for
// each request marked last, taken on an edge with o_valid high and i_stall low.
// Requests without i_last give no result.
// Throughput: one request per cycle while o_stall is low; the multiply-by-ten
// accumulator and phase update sit in the single stage after the input register.
// Pipeline: three register stages (input, end-of-value snapshot, result); a
// last request passes through them in that order before o_valid shows it.
// Reset (synchronous, active low) empties all stages and returns the parser
// to the leading whitespace phase.
// While the receiver stalls, the result holds; requests without i_last keep
// flowing, and o_stall rises only once a last request cannot advance because
// the snapshot and result stages are both full.
module byte_range_header_parser_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_ch,
    input  logic               i_has_char,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_status,
    output logic signed [63:0] o_range_start,
    output logic signed [63:0] o_range_length
);

    logic            r_i_valid, r_s_valid, r_o_valid;
    logic [7:0]      r_ch;
    logic            r_has_char, r_last;
    logic            out_free, snap_go, snap_free, in_go, in_free;
    brhp_pkg::t_snap snap;

    assign out_free  = !r_o_valid || !i_stall;
    assign snap_go   = r_s_valid && out_free;
    assign snap_free = !r_s_valid || snap_go;
    assign in_go     = r_i_valid && (!r_last || snap_free);
    assign in_free   = !r_i_valid || in_go;
    assign o_stall   = !in_free;
    assign o_valid   = r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (in_free) begin
                r_i_valid <= i_valid;
            end
            if (snap_free) begin
                r_s_valid <= in_go && r_last;
            end
            if (out_free) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && in_free) begin
            r_ch       <= i_ch;
            r_has_char <= i_has_char;
            r_last     <= i_last;
        end
    end

    brhp_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_go),
        .i_ch       (r_ch),
        .i_has_char (r_has_char),
        .i_last     (r_last),
        .o_snap     (snap)
    );

    brhp_result u_result (
        .i_clk          (i_clk),
        .i_load         (snap_go),
        .i_snap         (snap),
        .o_status       (o_status),
        .o_range_start  (o_range_start),
        .o_range_length (o_range_length)
    );

endmodule
